### sv/edge_tapered_vector_smoother_unit_macros.svh
// assertion macros for the edge tapered vector smoother
`ifndef EDGE_TAPERED_VECTOR_SMOOTHER_UNIT_MACROS_SVH
`define EDGE_TAPERED_VECTOR_SMOOTHER_UNIT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ETVS_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("etvs check failed");

// consequent in the cycle after the antecedent
`define ETVS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("etvs check failed");

`endif

### sv/etvs_pkg.sv
// shared constants, types and coefficient table of the smoother
`default_nettype none

package etvs_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int LENGTH_WIDTH = 16;
    localparam int DATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int TAPS         = 5;
    localparam int COEF_W       = 4;
    localparam int FLUSH_W      = 2;

    // weighted sum of ten tenths, plus sign
    localparam int SUM_W        = SAMPLE_WIDTH + 4;
    // magnitude plus rounding offset
    localparam int MAG_W        = SAMPLE_WIDTH + 3;
    // reciprocal of ten, exact for every magnitude below 2**MAG_W
    localparam int DIV_SHIFT    = SAMPLE_WIDTH + 7;
    localparam int RECIP_W      = SAMPLE_WIDTH + 4;
    localparam int PROD_W       = MAG_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << DIV_SHIFT) + 64'd9) / 64'd10;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [MAG_W-1:0] ROUND_OFS = MAG_W'(5);

    localparam logic [LENGTH_WIDTH-1:0] MIN_LENGTH = LENGTH_WIDTH'(3);

    typedef enum logic [2:0] {
        RULE_LAST,
        RULE_PENULT,
        RULE_FIRST,
        RULE_SECOND,
        RULE_FIVE,
        RULE_PASS
    } rule_t;

    typedef struct packed {
        logic eor;
        logic eov;
    } flags_t;

    typedef struct packed {
        rule_t  rule;
        flags_t flags;
    } job_t;

    typedef struct packed {
        logic s_ready;
        logic job_valid;
        logic flush_busy;
    } ctrl_stat_t;

    typedef struct packed {
        logic [LENGTH_WIDTH-1:0] nm1;
        logic [LENGTH_WIDTH-1:0] nm2;
        logic [LENGTH_WIDTH-1:0] nm3;
        logic [LENGTH_WIDTH-1:0] q;
        logic [LENGTH_WIDTH-1:0] lo;
    } lim_t;

    typedef logic [TAPS-1:0][COEF_W-1:0] coef_vec_t;

    // weights over window w0..w4, w4 the newest sample
    function automatic coef_vec_t rule_coefs(rule_t r);
        coef_vec_t c;
        c = '0;
        case (r)
            RULE_LAST:
            begin
                c[4] = COEF_W'(8);
                c[3] = COEF_W'(2);
            end
            RULE_PENULT:
            begin
                c[2] = COEF_W'(2);
                c[3] = COEF_W'(6);
                c[4] = COEF_W'(2);
            end
            RULE_FIRST:
            begin
                c[2] = COEF_W'(8);
                c[3] = COEF_W'(2);
            end
            RULE_SECOND:
            begin
                c[1] = COEF_W'(2);
                c[2] = COEF_W'(6);
                c[3] = COEF_W'(2);
            end
            RULE_FIVE:
            begin
                c[0] = COEF_W'(1);
                c[1] = COEF_W'(2);
                c[2] = COEF_W'(4);
                c[3] = COEF_W'(2);
                c[4] = COEF_W'(1);
            end
            RULE_PASS:
            begin
                // ten tenths divide back exactly
                c[2] = COEF_W'(10);
            end
            default:
            begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/etvs_cell.sv
// one sample cell of the history chain
`default_nettype none

module etvs_cell (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               shift,
    input  wire logic [etvs_pkg::SAMPLE_WIDTH-1:0]  d,
    output logic      [etvs_pkg::SAMPLE_WIDTH-1:0]  q
);
    import etvs_pkg::*;

    logic [SAMPLE_WIDTH-1:0] sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else if (shift)
        begin
            sample_reg <= d;
        end
    end

    assign q = sample_reg;

endmodule

`default_nettype wire

### sv/etvs_ctrl.sv
// position counter, flush sequencing and job issue
`default_nettype none

module etvs_ctrl (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               job_take,
    input  wire logic                               cfg_fire,
    input  wire logic [etvs_pkg::LENGTH_WIDTH-1:0]  cfg_len,
    output etvs_pkg::ctrl_stat_t                    stat,
    output etvs_pkg::job_t                          job
);
    import etvs_pkg::*;

    localparam logic [FLUSH_W-1:0] FLUSH_TWO = FLUSH_W'(2);
    localparam logic [FLUSH_W-1:0] FLUSH_ONE = FLUSH_W'(1);

    logic [LENGTH_WIDTH-1:0] pos_reg, pos_next;
    logic [FLUSH_W-1:0]      flush_reg, flush_next;
    logic                    job_valid_reg, job_valid_next;
    job_t                    job_reg, job_next;
    lim_t                    lim_reg, lim_next;

    logic                    job_free;
    logic                    in_fire;
    logic [LENGTH_WIDTH-1:0] n_eff;

    function automatic rule_t classify(logic [LENGTH_WIDTH-1:0] i, lim_t l);
        rule_t r;
        if (i == l.nm1)
            r = RULE_LAST;
        else if (i == l.nm2)
            r = RULE_PENULT;
        else if (i == '0)
            r = RULE_FIRST;
        else if (i == LENGTH_WIDTH'(1))
            r = RULE_SECOND;
        else if ((i >= LENGTH_WIDTH'(2) && i <= l.q) || (i >= l.lo && i <= l.nm3))
            r = RULE_FIVE;
        else
            r = RULE_PASS;
        return r;
    endfunction

    always_comb
    begin
        job_free       = !job_valid_reg || job_take;
        in_fire        = in_valid && job_free && (flush_reg == '0);

        pos_next       = pos_reg;
        flush_next     = flush_reg;
        job_valid_next = job_valid_reg && !job_take;
        job_next       = job_reg;
        lim_next       = lim_reg;
        n_eff          = (cfg_len < MIN_LENGTH) ? MIN_LENGTH : cfg_len;

        if (in_fire)
        begin
            if (pos_reg >= lim_reg.nm1)
            begin
                // last sample: three results, first one now
                job_valid_next     = 1'b1;
                job_next.rule      = classify(lim_reg.nm3, lim_reg);
                job_next.flags.eor = 1'b0;
                job_next.flags.eov = 1'b0;
                flush_next         = FLUSH_TWO;
                pos_next           = '0;
            end
            else
            begin
                if (pos_reg >= LENGTH_WIDTH'(2))
                begin
                    job_valid_next     = 1'b1;
                    job_next.rule      = classify(pos_reg - LENGTH_WIDTH'(2), lim_reg);
                    job_next.flags.eor = 1'b1;
                    job_next.flags.eov = 1'b0;
                end
                pos_next = pos_reg + LENGTH_WIDTH'(1);
            end
        end
        else if (job_free && flush_reg != '0)
        begin
            job_valid_next = 1'b1;
            flush_next     = flush_reg - FLUSH_ONE;
            if (flush_reg == FLUSH_TWO)
            begin
                job_next.rule      = RULE_PENULT;
                job_next.flags.eor = 1'b0;
                job_next.flags.eov = 1'b0;
            end
            else
            begin
                job_next.rule      = RULE_LAST;
                job_next.flags.eor = 1'b1;
                job_next.flags.eov = 1'b1;
            end
        end

        if (cfg_fire)
        begin
            pos_next     = '0;
            lim_next.nm1 = n_eff - LENGTH_WIDTH'(1);
            lim_next.nm2 = n_eff - LENGTH_WIDTH'(2);
            lim_next.nm3 = n_eff - LENGTH_WIDTH'(3);
            lim_next.q   = n_eff >> 2;
            lim_next.lo  = n_eff - LENGTH_WIDTH'(1) - (n_eff >> 2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            flush_reg     <= '0;
            job_valid_reg <= 1'b0;
            lim_reg.nm1   <= LENGTH_WIDTH'(2);
            lim_reg.nm2   <= LENGTH_WIDTH'(1);
            lim_reg.nm3   <= '0;
            lim_reg.q     <= '0;
            lim_reg.lo    <= LENGTH_WIDTH'(2);
        end
        else
        begin
            pos_reg       <= pos_next;
            flush_reg     <= flush_next;
            job_valid_reg <= job_valid_next;
            lim_reg       <= lim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign stat.s_ready    = job_free && (flush_reg == '0);
    assign stat.job_valid  = job_valid_reg;
    assign stat.flush_busy = (flush_reg != '0);
    assign job             = job_reg;

endmodule

`default_nettype wire

### sv/etvs_weight.sv
// weighted sum over the five cell taps
`default_nettype none

module etvs_weight (
    input  wire logic                                               clk,
    input  wire logic                                               load,
    input  wire etvs_pkg::job_t                                     job,
    input  wire logic [etvs_pkg::TAPS-1:0][etvs_pkg::SAMPLE_WIDTH-1:0] taps,
    output logic signed [etvs_pkg::SUM_W-1:0]                       sum,
    output etvs_pkg::flags_t                                        flags
);
    import etvs_pkg::*;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    flags_t                  flags_reg;
    coef_vec_t               coefs;

    always_comb
    begin
        coefs    = rule_coefs(job.rule);
        sum_next = '0;
        for (int j = 0; j < TAPS; j++)
        begin
            sum_next = sum_next + SUM_W'($signed(taps[j])) * SUM_W'($signed({1'b0, coefs[j]}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg   <= sum_next;
            flags_reg <= job.flags;
        end
    end

    assign sum   = sum_reg;
    assign flags = flags_reg;

endmodule

`default_nettype wire

### sv/etvs_div10.sv
// divide by ten, rounding halves away from zero, two stages
`default_nettype none

module etvs_div10 (
    input  wire logic                               clk,
    input  wire logic                               prod_load,
    input  wire logic                               res_load,
    input  wire logic signed [etvs_pkg::SUM_W-1:0]  sum,
    input  wire etvs_pkg::flags_t                   in_flags,
    output logic [etvs_pkg::SAMPLE_WIDTH-1:0]       smoothed,
    output etvs_pkg::flags_t                        out_flags
);
    import etvs_pkg::*;

    logic                    neg;
    logic [SUM_W-1:0]        abs_v;
    logic [MAG_W-1:0]        mag;
    logic [SAMPLE_WIDTH-1:0] quot;

    logic [PROD_W-1:0]       prod_reg;
    logic                    neg_reg;
    flags_t                  pflags_reg;
    logic [SAMPLE_WIDTH-1:0] smoothed_reg;
    flags_t                  oflags_reg;

    always_comb
    begin
        neg   = sum[SUM_W-1];
        abs_v = neg ? (~sum + SUM_W'(1)) : sum;
        mag   = abs_v[MAG_W-1:0] + ROUND_OFS;
        // quotient never exceeds half the sample range
        quot  = prod_reg[DIV_SHIFT +: SAMPLE_WIDTH];
    end

    always_ff @(posedge clk)
    begin
        if (prod_load)
        begin
            prod_reg   <= PROD_W'(mag) * PROD_W'(RECIP);
            neg_reg    <= neg;
            pflags_reg <= in_flags;
        end
        if (res_load)
        begin
            smoothed_reg <= neg_reg ? (~quot + SAMPLE_WIDTH'(1)) : quot;
            oflags_reg   <= pflags_reg;
        end
    end

    assign smoothed  = smoothed_reg;
    assign out_flags = oflags_reg;

endmodule

`default_nettype wire

### sv/edge_tapered_vector_smoother_unit.sv
// top level of the edge tapered vector smoother
//
//  channel   dir   handshake                    payload
//  s_axis    in    s_axis_tvalid/s_axis_tready  tdata[15:0] sample
//  m_axis    out   m_axis_tvalid/m_axis_tready  tdata[15:0] smoothed, tuser end_of_run,
//                                               tlast end_of_vector
//  cfg       in    cfg_valid/cfg_ready          cfg_data[15:0] vector_length
//
//  one sample per cycle unless a flush or an output stall holds it back; the last
//  sample of a vector holds s_axis_tready low while the two flush results are issued
//  from the five-cell chain, which does not shift meanwhile; a result passes the job
//  register (loaded at the sample transfer), the weighted sum, the reciprocal multiply
//  and the round and sign register before it shows on m_axis
//  a stall on m_axis fills the pipeline stages, then backs up into s_axis_tready
//  rst_n clears counters, valid bits and the sample cells; no clearing pass
`default_nettype none

module edge_tapered_vector_smoother_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // sample stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [etvs_pkg::DATA_W-1:0]        s_axis_tdata,   // [15:0] sample
    // result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic      [etvs_pkg::DATA_W-1:0]        m_axis_tdata,   // [15:0] smoothed
    output logic                                    m_axis_tuser,   // [0] end_of_run
    output logic                                    m_axis_tlast,   // end_of_vector
    // vector length register
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [etvs_pkg::LENGTH_WIDTH-1:0]  cfg_data
);
    import etvs_pkg::*;

    `include "edge_tapered_vector_smoother_unit_macros.svh"

    ctrl_stat_t              stat;
    job_t                    job;
    logic                    in_fire;
    logic                    cfg_fire;

    // cell chain: cell 0 holds the newest sample
    logic [SAMPLE_WIDTH-1:0] cell_q [TAPS];
    logic [TAPS-1:0][SAMPLE_WIDTH-1:0] taps;

    // pipeline occupancy
    logic                    s_valid_reg, s_valid_next;
    logic                    p_valid_reg, p_valid_next;
    logic                    o_valid_reg, o_valid_next;
    logic                    s_load, p_load, o_load;

    logic signed [SUM_W-1:0] sum;
    flags_t                  sum_flags;
    logic [SAMPLE_WIDTH-1:0] smoothed;
    flags_t                  out_flags;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    // stage advance, back to front
    always_comb
    begin
        o_load = p_valid_reg && (!o_valid_reg || m_axis_tready);
        p_load = s_valid_reg && (!p_valid_reg || o_load);
        s_load = stat.job_valid && (!s_valid_reg || p_load);

        o_valid_next = o_load ? 1'b1 : (o_valid_reg && !m_axis_tready);
        p_valid_next = p_load ? 1'b1 : (p_valid_reg && !o_load);
        s_valid_next = s_load ? 1'b1 : (s_valid_reg && !p_load);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    etvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .job_take (s_load),
        .cfg_fire (cfg_fire),
        .cfg_len  (cfg_data),
        .stat     (stat),
        .job      (job)
    );

    // cells shift only on a sample transfer, so a pending job sees a still window
    for (genvar g = 0; g < TAPS; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            etvs_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (in_fire),
                .d     (s_axis_tdata[SAMPLE_WIDTH-1:0]),
                .q     (cell_q[g])
            );
        end
        else
        begin : g_body
            etvs_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (in_fire),
                .d     (cell_q[g-1]),
                .q     (cell_q[g])
            );
        end
        // window slot TAPS-1 is the newest sample
        assign taps[TAPS-1-g] = cell_q[g];
    end

    etvs_weight u_weight (
        .clk   (clk),
        .load  (s_load),
        .job   (job),
        .taps  (taps),
        .sum   (sum),
        .flags (sum_flags)
    );

    etvs_div10 u_div10 (
        .clk       (clk),
        .prod_load (p_load),
        .res_load  (o_load),
        .sum       (sum),
        .in_flags  (sum_flags),
        .smoothed  (smoothed),
        .out_flags (out_flags)
    );

    assign s_axis_tready = stat.s_ready;
    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = DATA_W'(smoothed);
    assign m_axis_tuser  = out_flags.eor;
    assign m_axis_tlast  = out_flags.eov;

    // no sample taken while flush results are still being issued
    `ETVS_ASSERT_SAME(a_flush_blocks_input, clk, rst_n, stat.flush_busy, !s_axis_tready)
    // end of vector always closes the run
    `ETVS_ASSERT_SAME(a_eov_ends_run, clk, rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
    // a stalled output keeps the product stage occupied
    `ETVS_ASSERT_NEXT(a_stall_keeps_prod, clk, rst_n,
        p_valid_reg && o_valid_reg && !m_axis_tready, p_valid_reg)

endmodule

`default_nettype wire
